[hdl/shh_pkg.sv]
package shh_pkg;

   // Widths of the ports and of the configuration registers
   localparam int RATIO_W   = 16;
   localparam int RATIO_BITS = 16;
   localparam int COEF_W    = 32;
   localparam int SERIES_W  = 20;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;
   localparam int TEMP_W    = 16;
   localparam int STATUS_W  = 2;

   // Resistance numerator and log2 formats
   localparam int NUM_W     = SERIES_W + RATIO_BITS;
   localparam int E_W       = $clog2(NUM_W);
   localparam int FRAC_BITS = 24;
   localparam int L2_W      = E_W + FRAC_BITS;
   localparam int MANT_W    = 32;
   localparam int LOG_LAT   = FRAC_BITS + 1;

   localparam logic [RATIO_BITS:0] RATIO_FULL = (RATIO_BITS + 1)'(1) << RATIO_BITS;

   // ln2 in Q.30, rounding half and clamp of L
   localparam logic [29:0] LN2_Q30  = 30'd744261118;
   localparam logic [29:0] LN_ROUND = 30'd536870912;
   localparam int LM_W = 29;
   localparam logic [LM_W-1:0] LM_MAX = '1;

   // Polynomial widths
   localparam int BL_W   = COEF_W + LM_W - 24;
   localparam int LSQ_W  = 2 * LM_W - 24;
   localparam int L3_W   = LSQ_W + LM_W - 24;
   localparam int CHI_W  = COEF_W + L3_W - 24;
   localparam int P_W    = 48;
   localparam int Y_W    = 50;

   // Reciprocal
   localparam int DIV_W = 49;
   localparam logic [DIV_W-1:0] RECIP_NUM = DIV_W'(100) << 40;
   localparam logic [15:0] KELVIN_CENTI = 16'd27315;
   localparam logic [DIV_W-1:0] Q_LIMIT = DIV_W'(60082);
   localparam logic [TEMP_W-1:0] TEMP_MAX = 16'h7FFF;

   // Result queue
   localparam int FIFO_AW    = 7;
   localparam int FIFO_DEPTH = 1 << FIFO_AW;

   // Reset values of the registers
   localparam logic [COEF_W-1:0]   COEF_A_RST = 32'd1241779615;
   localparam logic [COEF_W-1:0]   COEF_B_RST = 32'd257397016;
   localparam logic [COEF_W-1:0]   COEF_C_RST = 32'd96358;
   localparam logic [SERIES_W-1:0] SERIES_RST = 20'd100000;

   typedef enum logic [STATUS_W-1:0] {
      ST_VALID = 2'd0,
      ST_OPEN  = 2'd1,
      ST_SAT   = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_COEF_A = 2'd0,
      REG_COEF_B = 2'd1,
      REG_COEF_C = 2'd2,
      REG_SERIES = 2'd3
   } csr_reg_type;

   // Per-beat control that travels with the data
   typedef struct packed {
      logic v;
      logic open_ckt;
      logic zero_res;
      logic nonpos;
   } ctl_type;

endpackage

[hdl/shh_log2.sv]
module shh_log2
   import shh_pkg::*;
(
   input  logic             clock,
   input  logic [NUM_W-1:0] x_in,
   output logic [L2_W-1:0]  log_out
);

   logic [E_W-1:0]       msb;
   logic [NUM_W-1:0]     norm;

   logic [E_W-1:0]       e_ff    [0:FRAC_BITS];
   logic [MANT_W-1:0]    m_ff    [0:FRAC_BITS];
   logic [FRAC_BITS-1:0] frac_ff [0:FRAC_BITS];

   // leading one position
   always_comb begin
      msb = '0;
      for (int i = 0; i < NUM_W; i++) begin
         if (x_in[i]) begin
            msb = E_W'(i);
         end
      end
   end

   // normalize mantissa to Q1.31
   assign norm = x_in << (E_W'(NUM_W - 1) - msb);

   always_ff @(posedge clock) begin
      e_ff[0]    <= msb;
      m_ff[0]    <= norm[NUM_W-1 -: MANT_W];
      frac_ff[0] <= '0;
   end

   // one squaring step per stage, one fraction bit each
   for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_sq
      logic [2*MANT_W-1:0] sq;
      logic [MANT_W:0]     top;

      assign sq  = m_ff[k-1] * m_ff[k-1];
      assign top = sq[2*MANT_W-1:MANT_W-1];

      always_ff @(posedge clock) begin
         e_ff[k]    <= e_ff[k-1];
         m_ff[k]    <= top[MANT_W] ? top[MANT_W:1] : top[MANT_W-1:0];
         frac_ff[k] <= {frac_ff[k-1][FRAC_BITS-2:0], top[MANT_W]};
      end
   end

   assign log_out = {e_ff[FRAC_BITS], frac_ff[FRAC_BITS]};

endmodule

[hdl/shh_div.sv]
module shh_div
   import shh_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [DIV_W-1:0] num_in,
   input  logic [DIV_W-1:0] den_in,
   input  ctl_type          ctl_in,
   output logic [DIV_W-1:0] quo_out,
   output ctl_type          ctl_out
);

   logic [DIV_W-1:0] rem_ff [0:DIV_W-1];
   logic [DIV_W-1:0] num_ff [0:DIV_W-1];
   logic [DIV_W-1:0] den_ff [0:DIV_W-1];
   logic [DIV_W-1:0] quo_ff [0:DIV_W-1];
   ctl_type          ctl_ff [0:DIV_W-1];

   // restoring division, one quotient bit per stage, MSB first
   for (genvar k = 0; k < DIV_W; k++) begin : g_stage
      logic [DIV_W-1:0] rem_prev;
      logic [DIV_W-1:0] num_prev;
      logic [DIV_W-1:0] den_prev;
      logic [DIV_W-1:0] quo_prev;
      ctl_type          ctl_prev;
      logic [DIV_W:0]   trial;
      logic [DIV_W:0]   diff;
      logic             fits;

      if (k == 0) begin : g_first
         assign rem_prev = '0;
         assign num_prev = num_in;
         assign den_prev = den_in;
         assign quo_prev = '0;
         assign ctl_prev = ctl_in;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign num_prev = num_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign quo_prev = quo_ff[k-1];
         assign ctl_prev = ctl_ff[k-1];
      end

      assign trial = {rem_prev, num_prev[DIV_W-1-k]};
      assign diff  = trial - {1'b0, den_prev};
      assign fits  = trial >= {1'b0, den_prev};

      always_ff @(posedge clock) begin
         rem_ff[k] <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         num_ff[k] <= num_prev;
         den_ff[k] <= den_prev;
         quo_ff[k] <= {quo_prev[DIV_W-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k] <= '0;
         end else begin
            ctl_ff[k] <= ctl_prev;
         end
      end
   end

   assign quo_out = quo_ff[DIV_W-1];
   assign ctl_out = ctl_ff[DIV_W-1];

endmodule

[hdl/thermistor_steinhart_hart_core.sv]
// Thermistor Steinhart-Hart converter.
// Input channel req_*: one beat carries a divider ratio (fraction of the
// supply, scaled by 2^16). Result channel rsp_*: one beat per input beat, in
// order, with the temperature in hundredths of a degree C and a status code
// (0 valid, 1 open circuit, 2 saturated or invalid).
// Configuration csr_*: write-only registers A, B, C (units 2^-40) and the
// series resistor in ohms; write them only while no beat is in flight.
// Throughput: one beat per cycle while req_ready is high. The datapath is a
// free-running pipeline (log2 by 24 squaring stages, then the polynomial,
// then a 49-stage restoring divider for 1/y) that never stalls.
// Results land in a 128-entry queue; req_ready stays high while fewer than
// 128 beats are in flight or queued, so a stalled receiver only holds off
// input once the queue could fill.
// Reset: synchronous, clears the pipeline, the queue and the credit count,
// and reloads the default coefficients (a 10k NTC with 100k series).
module thermistor_steinhart_hart_core
   import shh_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [RATIO_W-1:0]   req_ratio,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [TEMP_W-1:0]    rsp_temp_centi,
   output logic [STATUS_W-1:0]  rsp_status,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   // configuration registers
   logic [COEF_W-1:0]   coef_a_ff, coef_b_ff, coef_c_ff;
   logic [SERIES_W-1:0] series_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff <= COEF_A_RST;
         coef_b_ff <= COEF_B_RST;
         coef_c_ff <= COEF_C_RST;
         series_ff <= SERIES_RST;
      end else if (csr_wr_en) begin
         case (csr_reg_type'(csr_index))
            REG_COEF_A: coef_a_ff <= csr_wdata;
            REG_COEF_B: coef_b_ff <= csr_wdata;
            REG_COEF_C: coef_c_ff <= csr_wdata;
            REG_SERIES: series_ff <= csr_wdata[SERIES_W-1:0];
            default: ;
         endcase
      end
   end

   logic in_beat, out_beat;
   assign in_beat  = req_valid & req_ready;
   assign out_beat = rsp_valid & rsp_ready;

   // pipeline control
   ctl_type c0_ff, c1_ff, c2_ff, c3_ff, c4_ff, c5_ff, c6_ff, c7_ff, c8_ff, c9_ff;
   ctl_type ctl_dly_ff [0:LOG_LAT-1];
   ctl_type c0_in, c1_in, c9_in, cq;

   // data registers
   logic [RATIO_BITS-1:0] r0_ff, r1_ff;
   logic [NUM_W-1:0]      num1_ff;
   logic [L2_W-1:0]       log_num, log_r;
   logic                  neg2_ff, neg3_ff, neg4_ff, neg5_ff, neg6_ff, neg7_ff;
   logic [L2_W-1:0]       mag2_ff;
   logic [LM_W-1:0]       lm3_ff, lm4_ff;
   logic [BL_W-1:0]       bl4_ff, bl5_ff, bl6_ff;
   logic [LSQ_W-1:0]      sq4_ff;
   logic [L3_W-1:0]       l3_5_ff;
   logic [CHI_W-1:0]      chi6_ff;
   logic [COEF_W-1:0]     clo6_ff;
   logic [P_W-1:0]        p7_ff;
   logic [Y_W-1:0]        y8_ff;
   logic [DIV_W-1:0]      num9_ff, den9_ff, quo;

   // stage comb terms
   logic [RATIO_BITS:0]          inv_ratio;
   logic [SERIES_W+RATIO_BITS:0] num_full;
   logic [L2_W:0]                ldiff, ldiff_neg;
   logic [L2_W+30:0]             ln_prod;
   logic [L2_W:0]                lm_wide;
   logic [COEF_W+LM_W-1:0]       bl_full;
   logic [2*LM_W-1:0]            sq_full;
   logic [LSQ_W+LM_W-1:0]        l3_full;
   logic [CHI_W-1:0]             chi_full;
   logic [COEF_W+23:0]           clo_full;
   logic [Y_W-1:0]               ya, yp;

   assign c0_in = '{v: in_beat, open_ckt: (req_ratio[RATIO_BITS-1:0] == '0),
                    zero_res: 1'b0, nonpos: 1'b0};
   assign c1_in = '{v: c0_ff.v, open_ckt: c0_ff.open_ckt,
                    zero_res: (series_ff == '0), nonpos: 1'b0};

   assign inv_ratio = RATIO_FULL - {1'b0, r0_ff};
   assign num_full  = series_ff * inv_ratio;

   // log difference and its magnitude
   assign ldiff     = {1'b0, log_num} - {1'b0, log_r};
   assign ldiff_neg = ~ldiff + 1'b1;

   // L = |d| * ln2, rounded half up, clamped
   assign ln_prod = mag2_ff * LN2_Q30 + LN_ROUND;
   assign lm_wide = ln_prod[L2_W+30:30];

   // polynomial products
   assign bl_full  = coef_b_ff * lm3_ff;
   assign sq_full  = lm3_ff * lm3_ff;
   assign l3_full  = sq4_ff * lm4_ff;
   assign chi_full = coef_c_ff * l3_5_ff[L3_W-1:24];
   assign clo_full = coef_c_ff * l3_5_ff[23:0];

   assign ya = Y_W'(coef_a_ff);
   assign yp = Y_W'(p7_ff);

   assign c9_in = '{v: c8_ff.v, open_ckt: c8_ff.open_ckt, zero_res: c8_ff.zero_res,
                    nonpos: (y8_ff[Y_W-1] | (y8_ff == '0))};

   // control pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         c0_ff <= '0;
         c1_ff <= '0;
         c2_ff <= '0;
         c3_ff <= '0;
         c4_ff <= '0;
         c5_ff <= '0;
         c6_ff <= '0;
         c7_ff <= '0;
         c8_ff <= '0;
         c9_ff <= '0;
         for (int i = 0; i < LOG_LAT; i++) begin
            ctl_dly_ff[i] <= '0;
         end
      end else begin
         c0_ff <= c0_in;
         c1_ff <= c1_in;
         ctl_dly_ff[0] <= c1_ff;
         for (int i = 1; i < LOG_LAT; i++) begin
            ctl_dly_ff[i] <= ctl_dly_ff[i-1];
         end
         c2_ff <= ctl_dly_ff[LOG_LAT-1];
         c3_ff <= c2_ff;
         c4_ff <= c3_ff;
         c5_ff <= c4_ff;
         c6_ff <= c5_ff;
         c7_ff <= c6_ff;
         c8_ff <= c7_ff;
         c9_ff <= c9_in;
      end
   end

   // datapath pipeline
   always_ff @(posedge clock) begin
      r0_ff   <= req_ratio[RATIO_BITS-1:0];
      r1_ff   <= r0_ff;
      num1_ff <= num_full[NUM_W-1:0];
      // magnitude of the log difference
      neg2_ff <= ldiff[L2_W];
      mag2_ff <= ldiff[L2_W] ? ldiff_neg[L2_W-1:0] : ldiff[L2_W-1:0];
      // L
      neg3_ff <= neg2_ff;
      lm3_ff  <= (lm_wide > (L2_W + 1)'(LM_MAX)) ? LM_MAX : lm_wide[LM_W-1:0];
      // B*L and L^2
      neg4_ff <= neg3_ff;
      lm4_ff  <= lm3_ff;
      bl4_ff  <= bl_full[COEF_W+LM_W-1:24];
      sq4_ff  <= sq_full[2*LM_W-1:24];
      // L^3
      neg5_ff <= neg4_ff;
      bl5_ff  <= bl4_ff;
      l3_5_ff <= l3_full[LSQ_W+LM_W-1:24];
      // C*L^3 in two halves
      neg6_ff <= neg5_ff;
      bl6_ff  <= bl5_ff;
      chi6_ff <= chi_full;
      clo6_ff <= clo_full[COEF_W+23:24];
      // sum of the log terms
      neg7_ff <= neg6_ff;
      p7_ff   <= bl6_ff + chi6_ff + clo6_ff;
      // y
      y8_ff   <= neg7_ff ? (ya - yp) : (ya + yp);
      // rounded reciprocal operands
      den9_ff <= y8_ff[DIV_W-1:0];
      num9_ff <= RECIP_NUM + DIV_W'(y8_ff[DIV_W-1:1]);
   end

   shh_log2 u_log_num (
      .clock   (clock),
      .x_in    (num1_ff),
      .log_out (log_num)
   );

   shh_log2 u_log_ratio (
      .clock   (clock),
      .x_in    (NUM_W'(r1_ff)),
      .log_out (log_r)
   );

   shh_div u_div (
      .clock   (clock),
      .reset   (reset),
      .num_in  (num9_ff),
      .den_in  (den9_ff),
      .ctl_in  (c9_ff),
      .quo_out (quo),
      .ctl_out (cq)
   );

   // result formatting
   logic [TEMP_W-1:0] temp_res;
   status_type        status_res;
   logic [15:0]       temp_sub;

   assign temp_sub = quo[15:0] - KELVIN_CENTI;

   always_comb begin
      if (cq.open_ckt) begin
         temp_res   = '0;
         status_res = ST_OPEN;
      end else if (cq.zero_res || cq.nonpos || (quo > Q_LIMIT)) begin
         temp_res   = TEMP_MAX;
         status_res = ST_SAT;
      end else begin
         temp_res   = temp_sub;
         status_res = ST_VALID;
      end
   end

   // result queue and credit count
   logic [TEMP_W+STATUS_W-1:0] mem [0:FIFO_DEPTH-1];
   logic [FIFO_AW:0]           wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW:0]           rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]           credit_ff, credit_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [TEMP_W+STATUS_W-1:0] rsp_data_ff;
   logic                       q_empty, q_pop;

   assign q_empty = (wr_ptr_ff == rd_ptr_ff);
   assign q_pop   = (!rsp_valid_ff || rsp_ready) && !q_empty;

   always_comb begin
      wr_ptr_in    = wr_ptr_ff + (FIFO_AW + 1)'(cq.v);
      rd_ptr_in    = rd_ptr_ff + (FIFO_AW + 1)'(q_pop);
      credit_in    = credit_ff + (FIFO_AW + 1)'(in_beat) - (FIFO_AW + 1)'(out_beat);
      rsp_valid_in = q_pop ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         credit_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         credit_ff    <= credit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cq.v) begin
         mem[wr_ptr_ff[FIFO_AW-1:0]] <= {temp_res, status_res};
      end
      if (q_pop) begin
         rsp_data_ff <= mem[rd_ptr_ff[FIFO_AW-1:0]];
      end
   end

   assign req_ready      = ~credit_ff[FIFO_AW];
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_temp_centi = rsp_data_ff[TEMP_W+STATUS_W-1:STATUS_W];
   assign rsp_status     = rsp_data_ff[STATUS_W-1:0];

endmodule

[test/tb_thermistor_steinhart_hart_core.sv]
module tb_thermistor_steinhart_hart_core;
   import shh_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIPE_LAT   = 90;
   localparam int STALL_LONG = 500;
   localparam int WD_LIMIT   = 5000;

   typedef struct packed {
      logic [TEMP_W-1:0] temp;
      status_type        st;
   } temp_result_type;

   // one directed row: either a register write or an input beat
   typedef struct {
      bit                     wr;
      csr_reg_type            idx;
      logic [CSR_DAT_W-1:0]   data;
      logic [RATIO_W-1:0]     ratio;
      bit                     typed;
      logic [TEMP_W-1:0]      temp;
      status_type             st;
   } dir_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [RATIO_W-1:0]   req_ratio = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [TEMP_W-1:0]    rsp_temp_centi;
   logic [STATUS_W-1:0]  rsp_status;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   // shadow of the converter registers
   logic [63:0] sh_a, sh_b, sh_c, sh_series;

   temp_result_type temp_fifo[$];
   bit              row_typed = 1'b0;
   temp_result_type row_exp;
   int              n_sent = 0;
   int              n_checked = 0;
   int              n_errors = 0;
   int              idle_cnt = 0;
   bit              src_gaps = 1'b1;
   bit              sink_gaps = 1'b1;
   bit              stall_go = 1'b0;
   bit              held = 1'b0;
   dir_row_type     dir_rows[$];

   thermistor_steinhart_hart_core i_dut (.*);

   always #1 clock = ~clock;

   // log2 in Q.24 by normalization and repeated squaring
   function automatic logic [63:0] log2_fix(logic [63:0] x);
      int unsigned e;
      logic [63:0] m;
      logic [63:0] frac;
      e = 63;
      frac = '0;
      while (e > 0 && x[e] == 1'b0) e--;
      if (e >= 31) m = x >> (e - 31);
      else m = x << (31 - e);
      for (int i = 0; i < 24; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= (64'd1 << 32)) begin
            m = m >> 1;
            frac[0] = 1'b1;
         end
      end
      return (64'(e) << 24) | frac;
   endfunction

   // divider ratio -> temperature in centi-degrees and status
   function automatic temp_result_type predict_temp(logic [RATIO_W-1:0] ratio_in);
      logic [63:0] r, num, mag, lm, bl, l2, l3, cl3, p, uy, qq;
      longint d, y, t;
      bit neg;
      temp_result_type res;
      r = 64'(ratio_in);
      if (r == 0) return '{temp: '0, st: ST_OPEN};
      num = sh_series * ((64'd1 << RATIO_BITS) - r);
      if (num == 0) return '{temp: TEMP_MAX, st: ST_SAT};
      d = longint'(log2_fix(num)) - longint'(log2_fix(r));
      neg = d < 0;
      mag = neg ? 64'(-d) : 64'(d);
      lm = (mag * 64'd744261118 + (64'd1 << 29)) >> 30;
      if (lm > (64'd1 << 29) - 1) lm = (64'd1 << 29) - 1;
      bl = (sh_b * lm) >> 24;
      l2 = (lm * lm) >> 24;
      l3 = (l2 * lm) >> 24;
      cl3 = sh_c * (l3 >> 24) + ((sh_c * (l3 & 64'hFFFFFF)) >> 24);
      p = bl + cl3;
      y = longint'(sh_a) + (neg ? -longint'(p) : longint'(p));
      if (y <= 0) return '{temp: TEMP_MAX, st: ST_SAT};
      uy = 64'(y);
      qq = ((64'd100 << 40) + (uy >> 1)) / uy;
      t = longint'(qq) - 27315;
      if (t > 32767) res = '{temp: TEMP_MAX, st: ST_SAT};
      else if (t < -32768) res = '{temp: 16'h8000, st: ST_SAT};
      else res = '{temp: t[15:0], st: ST_VALID};
      return res;
   endfunction

   // input beats push expectations, result beats are checked against the oldest
   always @(posedge clock) begin
      temp_result_type want;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) idle_cnt <= 0;
         else idle_cnt <= idle_cnt + 1;
         if (idle_cnt >= WD_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
         if (req_valid && req_ready)
            temp_fifo.push_back(row_typed ? row_exp : predict_temp(req_ratio));
         if (rsp_valid && rsp_ready) begin
            n_checked <= n_checked + 1;
            if (temp_fifo.size() == 0) begin
               $display("%0t: unexpected beat temp=%0d status=%0d", $time,
                        $signed(rsp_temp_centi), rsp_status);
               n_errors++;
            end else begin
               want = temp_fifo.pop_front();
               if (rsp_temp_centi !== want.temp) begin
                  $display("%0t: temp_centi expected %0d got %0d", $time,
                           $signed(want.temp), $signed(rsp_temp_centi));
                  n_errors++;
               end
               if (rsp_status !== want.st) begin
                  $display("%0t: status expected %0d got %0d", $time, want.st, rsp_status);
                  n_errors++;
               end
            end
         end
      end
   end

   // receiver: random hold-off per beat, one long stall to back up the queue
   initial begin
      int n;
      @(posedge clock iff !reset);
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            n = sink_gaps ? $urandom_range(0, 6) : 0;
            if (stall_go && !held) begin
               held = 1'b1;
               n = STALL_LONG;
            end
            if (n > 0) begin
               rsp_ready <= 1'b0;
               repeat (n) @(posedge clock);
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   // one write strobe, then csr_wr_en is low again before the task returns
   task automatic csr_write(csr_reg_type idx, logic [CSR_DAT_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         REG_COEF_A: sh_a = 64'(data);
         REG_COEF_B: sh_b = 64'(data);
         REG_COEF_C: sh_c = 64'(data);
         REG_SERIES: sh_series = 64'(data[SERIES_W-1:0]);
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_ratio(logic [RATIO_W-1:0] r, bit typed, temp_result_type e);
      int gap;
      gap = src_gaps ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ratio <= r;
      row_typed <= typed;
      row_exp   <= e;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      n_sent++;
   endtask

   // wait until every beat is back, then let the pipeline settle
   task automatic drain();
      req_valid <= 1'b0;
      while (n_checked != n_sent) @(posedge clock);
      repeat (PIPE_LAT) @(posedge clock);
   endtask

   function automatic dir_row_type wr_row(csr_reg_type idx, logic [CSR_DAT_W-1:0] data);
      return '{wr: 1'b1, idx: idx, data: data, ratio: '0, typed: 1'b0, temp: '0, st: ST_VALID};
   endfunction

   function automatic dir_row_type beat_row(logic [RATIO_W-1:0] r, bit typed = 1'b0,
                                            logic [TEMP_W-1:0] t = '0,
                                            status_type st = ST_VALID);
      return '{wr: 1'b0, idx: REG_COEF_A, data: '0, ratio: r, typed: typed, temp: t, st: st};
   endfunction

   function automatic logic [31:0] near(logic [31:0] base, int unsigned span);
      return base + $urandom_range(0, span) - span / 2;
   endfunction

   initial begin
      bit was_wr;
      int n_items;
      logic [RATIO_W-1:0] r;
      sh_a = COEF_A_RST;
      sh_b = COEF_B_RST;
      sh_c = COEF_C_RST;
      sh_series = SERIES_RST;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset defaults, extremes, open circuit, zero series,
      // non-positive y, overflow, register masking
      dir_rows = '{
         beat_row(16'd0, 1'b1, 16'd0, ST_OPEN), beat_row(16'd1), beat_row(16'hFFFF),
         beat_row(16'h8000), beat_row(16'h5555), beat_row(16'hAAAA), beat_row(16'h1234),
         wr_row(REG_COEF_A, 32'd0), wr_row(REG_COEF_B, 32'd0), wr_row(REG_COEF_C, 32'd0),
         beat_row(16'd1000, 1'b1, TEMP_MAX, ST_SAT),
         wr_row(REG_COEF_A, 32'd1),
         beat_row(16'h8000, 1'b1, TEMP_MAX, ST_SAT),
         wr_row(REG_COEF_B, 32'hFFFFFFFF), wr_row(REG_COEF_C, 32'hFFFFFFFF),
         wr_row(REG_SERIES, 32'd1),
         beat_row(16'hFFFF), beat_row(16'd1), beat_row(16'h8000),
         wr_row(REG_SERIES, 32'd0),
         beat_row(16'd100, 1'b1, TEMP_MAX, ST_SAT), beat_row(16'hFFFF, 1'b1, TEMP_MAX, ST_SAT),
         beat_row(16'd0, 1'b1, 16'd0, ST_OPEN),
         wr_row(REG_COEF_A, 32'hFFFFFFFF), wr_row(REG_SERIES, 32'hFFFFFFFF),
         beat_row(16'd1), beat_row(16'hFFFF), beat_row(16'h00FF),
         wr_row(REG_COEF_A, COEF_A_RST), wr_row(REG_COEF_B, COEF_B_RST),
         wr_row(REG_COEF_C, COEF_C_RST), wr_row(REG_SERIES, 32'(SERIES_RST))
      };
      was_wr = 1'b1;
      foreach (dir_rows[i]) begin
         if (dir_rows[i].wr) begin
            if (!was_wr) drain();
            csr_write(dir_rows[i].idx, dir_rows[i].data);
         end else begin
            send_ratio(dir_rows[i].ratio, dir_rows[i].typed,
                       '{temp: dir_rows[i].temp, st: dir_rows[i].st});
         end
         was_wr = dir_rows[i].wr;
      end
      drain();

      // random phases: a register setting (except in the first), then a burst of ratios
      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0) begin
            case (ph)
               2: begin
                  csr_write(REG_COEF_A, $urandom());
                  csr_write(REG_COEF_B, $urandom());
                  csr_write(REG_COEF_C, $urandom());
                  csr_write(REG_SERIES, $urandom());
               end
               4: begin
                  csr_write(REG_COEF_A, 32'hFFFFFFFF);
                  csr_write(REG_COEF_B, near(COEF_B_RST, 1 << 20));
                  csr_write(REG_COEF_C, 32'd0);
                  csr_write(REG_SERIES, $urandom_range(1, 2000));
               end
               default: begin
                  csr_write(REG_COEF_A, near(COEF_A_RST, 1 << 26));
                  csr_write(REG_COEF_B, near(COEF_B_RST, 1 << 24));
                  csr_write(REG_COEF_C, near(COEF_C_RST, 1 << 14));
                  csr_write(REG_SERIES, $urandom_range(1000, 1048575));
               end
            endcase
         end
         src_gaps  = (ph != 1);
         sink_gaps = (ph != 3);
         // the long burst outlasts the queue while the receiver holds off
         stall_go  = (ph == 1);
         n_items   = (ph == 1) ? 200 : 80;
         for (int k = 0; k < n_items; k++) begin
            case ($urandom_range(0, 9))
               0: r = $urandom_range(0, 15);
               1: r = 16'hFFFF - $urandom_range(0, 15);
               default: r = $urandom();
            endcase
            send_ratio(r, 1'b0, '0);
         end
         drain();
      end

      if (n_errors == 0 && temp_fifo.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
